>>> hw/rtl/sha256_pkg.sv
package sha256_pkg;

    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
    } item_t;

    localparam logic [31:0] KROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] KINIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> hw/rtl/sha256_queue.sv
module sha256_queue #(
    parameter int DEPTH = sha256_pkg::QueueDepth
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sha256_pkg::item_t   in_item,
    output logic                out_valid,
    input  logic                out_take,
    output sha256_pkg::item_t   out_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha256_pkg::item_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          push, pop;

    assign in_stall  = (cnt_reg == (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_reg];
    assign push = in_valid && !in_stall;
    assign pop  = out_valid && out_take;

    always_comb
    begin
        wr_next  = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        rd_next  = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_next;
            end
            if (pop)
            begin
                rd_reg <= rd_next;
            end
            cnt_reg <= cnt_next;
        end
    end
endmodule

>>> hw/rtl/sha256_core.sv
module sha256_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_take,
    input  sha256_pkg::item_t item,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       digest_word,
    output logic [2:0]        word_number,
    output logic              last_word
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_LEN   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;      // bytes in block, 0..63
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;
    logic        final_reg;     // compressing the length block
    logic        len_blk_reg;   // length goes into a block of its own
    logic        last_reg;      // message end waits behind a full block
    logic [2:0]  onum_reg;

    logic [31:0] s0, s1, wnew, se, ch, sa, maj, t1, t2;
    logic [31:0] word_ins;
    logic [31:0] pad_word;
    logic [31:0] pad_w [16];
    logic [1:0]  bsel;
    logic [3:0]  wsel;
    logic        block_full, len_fits, start_rounds, word_sent;

    // message schedule: w_reg[0] is the word of this round
    always_comb
    begin
        s0   = sha256_pkg::ror32(w_reg[1], 7) ^ sha256_pkg::ror32(w_reg[1], 18)
             ^ (w_reg[1] >> 3);
        s1   = sha256_pkg::ror32(w_reg[14], 17) ^ sha256_pkg::ror32(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        se   = sha256_pkg::ror32(v_reg[4], 6) ^ sha256_pkg::ror32(v_reg[4], 11)
             ^ sha256_pkg::ror32(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + se + ch + sha256_pkg::KROUND[rnd_reg] + w_reg[0];
        sa   = sha256_pkg::ror32(v_reg[0], 2) ^ sha256_pkg::ror32(v_reg[0], 13)
             ^ sha256_pkg::ror32(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = sa + maj;
    end

    assign wsel = fill_reg[5:2];
    assign bsel = fill_reg[1:0];

    assign item_take    = (state_reg == ST_IDLE) && item_valid;
    assign block_full   = item.has_byte && (fill_reg == 6'd63);
    assign len_fits     = (fill_reg < 6'd56);
    assign start_rounds = (state_next == ST_ROUND) && (state_reg != ST_ROUND);
    assign word_sent    = out_valid && !out_stall;

    // byte insertion, big-endian within each word
    always_comb
    begin
        word_ins = w_reg[wsel];
        case (bsel)
            2'd0:    word_ins[31:24] = item.data_byte;
            2'd1:    word_ins[23:16] = item.data_byte;
            2'd2:    word_ins[15:8]  = item.data_byte;
            default: word_ins[7:0]   = item.data_byte;
        endcase
    end

    // pad marker after the last byte, zeros behind it, length when it fits
    always_comb
    begin
        case (bsel)
            2'd0:    pad_word = {sha256_pkg::PAD_BYTE, 24'h0};
            2'd1:    pad_word = {w_reg[wsel][31:24], sha256_pkg::PAD_BYTE, 16'h0};
            2'd2:    pad_word = {w_reg[wsel][31:16], sha256_pkg::PAD_BYTE, 8'h0};
            default: pad_word = {w_reg[wsel][31:8], sha256_pkg::PAD_BYTE};
        endcase
        for (int i = 0; i < 16; i++)
        begin
            if (4'(i) < wsel)
                pad_w[i] = w_reg[i];
            else if (4'(i) == wsel)
                pad_w[i] = pad_word;
            else
                pad_w[i] = '0;
        end
        if (len_fits)
        begin
            pad_w[14] = len_reg[63:32];
            pad_w[15] = len_reg[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    if (block_full)
                        state_next = ST_ROUND;
                    else if (item.last_item)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (final_reg)
                    state_next = ST_OUT;
                else if (len_blk_reg)
                    state_next = ST_LEN;
                else if (last_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_PAD:
            begin
                state_next = ST_ROUND;
            end
            ST_LEN:
            begin
                state_next = ST_ROUND;
            end
            ST_OUT:
            begin
                if (word_sent && onum_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = h_reg[onum_reg];
    assign word_number = onum_reg;
    assign last_word   = (onum_reg == 3'd7);

    // block words and working variables
    always_ff @(posedge clk)
    begin
        if (start_rounds)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (item_take && item.has_byte)
                begin
                    w_reg[wsel] <= word_ins;
                end
            end
            ST_PAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    w_reg[i] <= pad_w[i];
                end
            end
            ST_LEN:
            begin
                for (int i = 0; i < 14; i++)
                begin
                    w_reg[i] <= '0;
                end
                w_reg[14] <= len_reg[63:32];
                w_reg[15] <= len_reg[31:0];
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= wnew;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::KINIT[i];
            end
            fill_reg    <= '0;
            len_reg     <= '0;
            rnd_reg     <= '0;
            final_reg   <= 1'b0;
            len_blk_reg <= 1'b0;
            last_reg    <= 1'b0;
            onum_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // 64 steps per block, so it is back at zero for the next one
            if (state_reg == ST_ROUND)
            begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_take)
                    begin
                        last_reg <= item.last_item;
                        if (item.has_byte)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                            len_reg  <= len_reg + 64'd8;
                        end
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                ST_PAD:
                begin
                    fill_reg    <= '0;
                    last_reg    <= 1'b0;
                    final_reg   <= len_fits;
                    len_blk_reg <= !len_fits;
                end
                ST_LEN:
                begin
                    final_reg   <= 1'b1;
                    len_blk_reg <= 1'b0;
                end
                ST_OUT:
                begin
                    if (word_sent)
                    begin
                        onum_reg <= onum_reg + 3'd1;
                        if (onum_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha256_pkg::KINIT[i];
                            end
                            len_reg   <= '0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

>>> hw/rtl/sha256_message_digest_top.sv
// sha-256 digest engine: bytes come in one per item (has_byte low with
// last_item high ends a message with no new byte, so an empty message works)
// and each message ends with eight 32-bit digest words, word 0 first, with
// last_word on word 7. items first land in a four-deep queue; the engine
// behind it takes one item per cycle while gathering a block, runs the
// rounds and then an add step after every 64th byte, and on the last item
// runs a pad step, the rounds and an add step (and then a length block
// through the rounds and add again when the last block holds 56 or more
// bytes) before offering the words; each word then leaves once out_stall
// is low
module sha256_message_digest_top #(
    parameter int QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_word
);
    // input item packed for the queue
    sha256_pkg::item_t in_item;
    // head of the queue as seen by the engine
    sha256_pkg::item_t q_item;
    logic              q_valid;
    logic              q_take;

    assign in_item = {data_byte, has_byte, last_item};

    // front: holds items while the engine is busy compressing or emitting
    sha256_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) queue_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(q_valid),
        .out_take(q_take),
        .out_item(q_item)
    );

    // back: gathers blocks, pads, compresses and emits the digest
    sha256_core core_i (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(q_valid),
        .item_take(q_take),
        .item(q_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .digest_word(digest_word),
        .word_number(word_number),
        .last_word(last_word)
    );

    // a stalled digest word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word)
            && $stable(word_number) && $stable(last_word));

    // last_word marks word 7 only
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_number == 3'd7)));

    // handshake outputs are always known
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}));
endmodule
